/* hdl/hcbp_pkg.sv */
`default_nettype none

package hcbp_pkg;

    // Operation codes carried on op
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int SYMBOL_W = 8;
    localparam int WORD_W   = 32;
    localparam int BYTE_W   = 8;

    // Bits that can wait in the accumulator between items
    localparam int PEND_W   = 7;
    localparam int PCOUNT_W = 3;

    // Defaults for the top-level parameters
    localparam int SYMBOL_COUNT_DEF = 256;
    localparam int CODE_WIDTH_DEF   = 32;

endpackage

`default_nettype wire

/* hdl/hcbp_ram.sv */
`default_nettype none

module hcbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/huffman_code_bit_packer.sv */
// Huffman code bit packer.
// Input channel (in_valid / in_stall): op selects load, encode or flush.
//   Load writes code_word into the code table at symbol; encode looks up
//   symbol and appends the code bits below the marker bit to the pending
//   accumulator; flush emits the pending partial byte, left-aligned and
//   zero padded, and clears the accumulator.
// Output channel (out_valid / out_stall): one packed byte per transfer,
//   earliest code bit in bit 7; last marks the final byte of an item.
//   Items that produce no byte (load, empty code, flush with nothing
//   pending) produce no transfer.
// The first byte of an item is offered from the byte register: the table
//   is read at the taking edge, then the item is packed into the byte
//   register once that register is free.
// Throughput: one item per cycle while each item gives at most one byte
//   and out_stall is low; an item giving more bytes holds the byte
//   register until its last byte leaves, so the byte port sets the rate.
// Reset clears the accumulator and both pipeline stages; the code table is
//   not cleared and must be loaded before encoding.
// While out_stall is high the offered byte holds; one item more is taken
//   into the lookup stage, after which in_stall rises.
`default_nettype none

module huffman_code_bit_packer #(
    parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF,
    parameter int CODE_WIDTH   = hcbp_pkg::CODE_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire logic [hcbp_pkg::OP_W-1:0]     op,
    input  wire logic [hcbp_pkg::SYMBOL_W-1:0] symbol,
    input  wire logic [hcbp_pkg::WORD_W-1:0]   code_word,
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      logic [hcbp_pkg::BYTE_W-1:0]   out_byte,
    output      logic                          last
);

    localparam int AW        = $clog2(SYMBOL_COUNT);
    localparam int LEN_W     = $clog2(CODE_WIDTH);
    localparam int ACC_W     = hcbp_pkg::PEND_W + CODE_WIDTH - 1;
    localparam int TOT_W     = $clog2(hcbp_pkg::PEND_W + CODE_WIDTH);
    localparam int MAX_BYTES = ACC_W / hcbp_pkg::BYTE_W;
    localparam int RES_W     = MAX_BYTES * hcbp_pkg::BYTE_W;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    // Lookup stage
    logic                  s1_valid_reg, s1_valid_next;
    logic [hcbp_pkg::OP_W-1:0] s1_op_reg;
    logic                  s1_hit_reg;
    logic [CODE_WIDTH-1:0] key;

    // Accumulator
    logic [hcbp_pkg::PEND_W-1:0]   pend_bits_reg, pend_bits_next;
    logic [hcbp_pkg::PCOUNT_W-1:0] pend_count_reg, pend_count_next;

    // Byte register
    logic [RES_W-1:0] res_bytes_reg, res_bytes_next;
    logic [CNT_W-1:0] res_count_reg, res_count_next;

    logic in_fire, out_fire, res_free, s1_go, sym_hit;

    logic [LEN_W-1:0]             len;
    logic [CODE_WIDTH-1:0]        code_bits;
    logic [ACC_W-1:0]             acc;
    logic [TOT_W-1:0]             total;
    logic [ACC_W+RES_W-1:0]       wide;
    logic [hcbp_pkg::PEND_W+hcbp_pkg::BYTE_W-1:0] flush_wide;

    assign sym_hit = ({1'b0, symbol} < (hcbp_pkg::SYMBOL_W+1)'(SYMBOL_COUNT));

    assign out_valid = (res_count_reg != '0);
    assign out_fire  = out_valid && !out_stall;
    assign out_byte  = res_bytes_reg[RES_W-1 -: hcbp_pkg::BYTE_W];
    assign last      = (res_count_reg == CNT_W'(1));

    // The byte register can take a new item once its last byte leaves
    assign res_free = (res_count_reg == '0) || ((res_count_reg == CNT_W'(1)) && out_fire);
    assign s1_go    = s1_valid_reg && res_free;
    assign in_stall = s1_valid_reg && !res_free;
    assign in_fire  = in_valid && !in_stall;

    hcbp_ram #(
        .WIDTH (CODE_WIDTH),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .clk     (clk),
        .wr_en   (in_fire && (op == hcbp_pkg::OP_LOAD) && sym_hit),
        .wr_addr (symbol[AW-1:0]),
        .wr_data (code_word[CODE_WIDTH-1:0]),
        .rd_en   (in_fire && (op == hcbp_pkg::OP_ENCODE)),
        .rd_addr (symbol[AW-1:0]),
        .rd_data (key)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg  <= op;
            s1_hit_reg <= sym_hit;
        end
    end

    // Marker position: highest set bit of the code word
    always_comb
    begin
        len = '0;
        for (int i = 1; i < CODE_WIDTH; i++)
        begin
            if (key[i])
            begin
                len = LEN_W'(i);
            end
        end
    end

    assign code_bits  = key & ~({CODE_WIDTH{1'b1}} << len);
    assign acc        = (ACC_W'(pend_bits_reg) << len) | ACC_W'(code_bits);
    assign total      = TOT_W'(pend_count_reg) + TOT_W'(len);
    // Left-align the valid accumulator bits at the top of the byte field
    assign wide       = {acc, {RES_W{1'b0}}} >> total;
    assign flush_wide = {pend_bits_reg, {hcbp_pkg::BYTE_W{1'b0}}} >> pend_count_reg;

    always_comb
    begin
        pend_bits_next  = pend_bits_reg;
        pend_count_next = pend_count_reg;
        res_bytes_next  = res_bytes_reg;
        res_count_next  = res_count_reg;

        if (out_fire)
        begin
            res_bytes_next = res_bytes_reg << hcbp_pkg::BYTE_W;
            res_count_next = res_count_reg - CNT_W'(1);
        end

        if (s1_go)
        begin
            res_count_next = '0;
            case (s1_op_reg)
                hcbp_pkg::OP_ENCODE:
                begin
                    if (s1_hit_reg && (len != '0))
                    begin
                        res_bytes_next  = wide[RES_W-1:0];
                        res_count_next  = CNT_W'(total >> $clog2(hcbp_pkg::BYTE_W));
                        pend_count_next = total[hcbp_pkg::PCOUNT_W-1:0];
                        pend_bits_next  = acc[hcbp_pkg::PEND_W-1:0]
                                          & ~({hcbp_pkg::PEND_W{1'b1}}
                                              << total[hcbp_pkg::PCOUNT_W-1:0]);
                    end
                end
                hcbp_pkg::OP_FLUSH:
                begin
                    if (pend_count_reg != '0)
                    begin
                        res_bytes_next = RES_W'(flush_wide[hcbp_pkg::BYTE_W-1:0])
                                         << (RES_W - hcbp_pkg::BYTE_W);
                        res_count_next = CNT_W'(1);
                    end
                    pend_bits_next  = '0;
                    pend_count_next = '0;
                end
                default:
                begin
                    // load and unused codes leave the accumulator alone
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg  <= '0;
            pend_count_reg <= '0;
            res_count_reg  <= '0;
        end
        else
        begin
            pend_bits_reg  <= pend_bits_next;
            pend_count_reg <= pend_count_next;
            res_count_reg  <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_bytes_reg <= res_bytes_next;
    end

endmodule

`default_nettype wire
